// ===== sv/nvfp_pkg.sv =====
// nvfp_pkg: shared types, constants and header byte function for the frame packer
// no dependencies; imported by every module of the block
package nvfp_pkg;

   localparam int HEADER_BYTES = 20;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_AW    = 2;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_END    = 1'b1;

   localparam logic [2:0] KIND_BOOL  = 3'd0;
   localparam logic [2:0] KIND_BYTE  = 3'd1;
   localparam logic [2:0] KIND_WORD  = 3'd2;
   localparam logic [2:0] KIND_DWORD = 3'd3;
   localparam logic [2:0] KIND_REAL  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_BIG_ENDIAN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PACK_BOOLS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OBJECT_ID     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIST_CHECKSUM = 3'd4;

   localparam logic [7:0] MAGIC_0 = 8'h00;
   localparam logic [7:0] MAGIC_1 = 8'h2D;
   localparam logic [7:0] MAGIC_2 = 8'h53;
   localparam logic [7:0] MAGIC_3 = 8'h33;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  var_kind;
      logic [31:0] var_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        big_endian;
      logic        pack_bools;
      logic        align_enable;
      logic [15:0] object_id;
      logic [15:0] list_checksum;
   } cfg_type;

   // one queued job: optional bool byte, zero pad, then body bytes
   // header jobs carry {total length, sequence} in value
   typedef struct packed {
      logic        is_header;
      logic        flush;
      logic [7:0]  flush_byte;
      logic [1:0]  pad_cnt;
      logic [4:0]  body_cnt;
      logic [31:0] value;
      logic [15:0] start_offset;
   } job_type;

   function automatic logic [7:0] word_byte(input logic be, input logic second,
                                            input logic [15:0] w);
      if (be ^ second) begin
         return w[15:8];
      end
      return w[7:0];
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [4:0] pos, input cfg_type cfg,
                                           input logic [15:0] tot_len,
                                           input logic [15:0] seq);
      logic [7:0] b;
      b = 8'h00;
      case (pos)
         5'd0:  b = MAGIC_0;
         5'd1:  b = MAGIC_1;
         5'd2:  b = MAGIC_2;
         5'd3:  b = MAGIC_3;
         5'd8:  b = word_byte(cfg.big_endian, 1'b0, cfg.object_id);
         5'd9:  b = word_byte(cfg.big_endian, 1'b1, cfg.object_id);
         5'd12: b = word_byte(cfg.big_endian, 1'b0, cfg.list_checksum);
         5'd13: b = word_byte(cfg.big_endian, 1'b1, cfg.list_checksum);
         5'd14: b = word_byte(cfg.big_endian, 1'b0, tot_len);
         5'd15: b = word_byte(cfg.big_endian, 1'b1, tot_len);
         5'd16: b = word_byte(cfg.big_endian, 1'b0, seq);
         5'd17: b = word_byte(cfg.big_endian, 1'b1, seq);
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== sv/nvfp_front.sv =====
// nvfp_front: accepts words, tracks payload length, bool packing and sequence,
// and turns each word into at most one byte job; depends on nvfp_pkg
module nvfp_front import nvfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    job_full,
   output logic    job_push,
   output job_type job
);

   logic [15:0] len_ff, len_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [15:0] seq_ff, seq_in;

   logic        accept;
   logic        is_end;
   logic        known;
   logic        is_bool;
   logic        packed_bool;
   logic        flush;
   logic [15:0] len1;
   logic [2:0]  size;
   logic        align2;
   logic        align4;
   logic [1:0]  pad;
   logic [7:0]  new_acc;

   assign req_full    = job_full;
   assign accept      = req_push && !job_full;
   assign is_end      = req_data.opcode == OP_END;
   assign known       = req_data.var_kind <= KIND_REAL;
   assign is_bool     = req_data.var_kind == KIND_BOOL;
   assign packed_bool = is_bool && cfg.pack_bools;
   // a pending bool byte goes out ahead of any known non-bool word and ahead of an end of frame
   assign flush       = is_end ? pend_ff : (known && !is_bool && pend_ff);
   assign len1        = len_ff + {15'b0, flush};
   assign new_acc     = acc_ff | ({7'b0, req_data.var_value[0]} << cnt_ff);

   always_comb begin
      size   = 3'd1;
      align2 = 1'b0;
      align4 = 1'b0;
      case (req_data.var_kind)
         KIND_WORD: begin
            size   = 3'd2;
            align2 = 1'b1;
         end
         KIND_DWORD: begin
            size   = 3'd4;
            align4 = 1'b1;
         end
         KIND_REAL: begin
            size   = 3'd4;
            align2 = 1'b1;
         end
         default: size = 3'd1;
      endcase
   end

   always_comb begin
      pad = 2'd0;
      if (cfg.align_enable) begin
         if (align4) begin
            pad = 2'd0 - len1[1:0];
         end else if (align2) begin
            pad = {1'b0, len1[0]};
         end
      end
   end

   always_comb begin
      len_in  = len_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      seq_in  = seq_ff;
      job              = '0;
      job.flush_byte   = acc_ff;
      job.value        = req_data.var_value;
      job.start_offset = 16'(HEADER_BYTES) + len_ff;
      job_push         = 1'b0;
      if (is_end) begin
         job_push      = accept;
         job.is_header = 1'b1;
         job.flush     = flush;
         job.body_cnt  = 5'(HEADER_BYTES);
         job.value     = {16'(HEADER_BYTES) + len1, seq_ff};
         seq_in  = seq_ff + 16'd1;
         len_in  = 16'd0;
         acc_in  = 8'd0;
         cnt_in  = 3'd0;
         pend_in = 1'b0;
      end else if (known && packed_bool) begin
         if (cnt_ff == 3'd7) begin
            job_push       = accept;
            job.flush      = 1'b1;
            job.flush_byte = new_acc;
            len_in  = len_ff + 16'd1;
            acc_in  = 8'd0;
            cnt_in  = 3'd0;
            pend_in = 1'b0;
         end else begin
            acc_in  = new_acc;
            cnt_in  = cnt_ff + 3'd1;
            pend_in = 1'b1;
         end
      end else if (known) begin
         job_push     = accept;
         job.flush    = flush;
         job.pad_cnt  = pad;
         job.body_cnt = {2'b0, size};
         if (is_bool) begin
            job.value = {31'b0, req_data.var_value[0]};
         end
         len_in = len1 + {14'b0, pad} + {13'b0, size};
         if (flush) begin
            acc_in  = 8'd0;
            cnt_in  = 3'd0;
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 16'd0;
         acc_ff  <= 8'd0;
         cnt_ff  <= 3'd0;
         pend_ff <= 1'b0;
         seq_ff  <= 16'd0;
      end else if (accept) begin
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
         seq_ff  <= seq_in;
      end
   end

endmodule

// ===== sv/nvfp_jobq.sv =====
// nvfp_jobq: short register queue of byte jobs between front and back
// depends on nvfp_pkg
module nvfp_jobq import nvfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type              mem_ff [JOBQ_DEPTH];
   logic [JOBQ_AW-1:0]   wr_ff, wr_in;
   logic [JOBQ_AW-1:0]   rd_ff, rd_in;
   logic [JOBQ_AW:0]     cnt_ff, cnt_in;

   assign full  = cnt_ff == (JOBQ_AW+1)'(JOBQ_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/nvfp_back.sv =====
// nvfp_back: walks the head job one byte per cycle into the output register while that register is empty or popped
// depends on nvfp_pkg
module nvfp_back import nvfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_empty,
   input  job_type head,
   output logic    job_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   logic [4:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;

   logic       load;
   logic [4:0] lead;
   logic [4:0] total;
   logic [4:0] b;
   logic [1:0] sel;
   logic [7:0] pay_byte;
   logic       last;

   assign lead  = {4'b0, head.flush} + {3'b0, head.pad_cnt};
   assign total = lead + head.body_cnt;
   assign b     = idx_ff - lead;
   assign last  = idx_ff == total - 5'd1;
   assign load  = !job_empty && (!valid_ff || rsp_pop);
   assign job_pop = load && last;

   // big endian counts down from the top body byte of the value
   assign sel = cfg.big_endian ? head.body_cnt[1:0] - 2'd1 - b[1:0] : b[1:0];

   always_comb begin
      case (sel)
         2'd0:    pay_byte = head.value[7:0];
         2'd1:    pay_byte = head.value[15:8];
         2'd2:    pay_byte = head.value[23:16];
         2'd3:    pay_byte = head.value[31:24];
         default: pay_byte = 8'h00;
      endcase
   end

   always_comb begin
      out_in = out_ff;
      if (load) begin
         out_in.last        = last;
         out_in.byte_offset = head.start_offset + {11'b0, idx_ff};
         if (idx_ff < {4'b0, head.flush}) begin
            out_in.out_byte = head.flush_byte;
         end else if (idx_ff < lead) begin
            out_in.out_byte = 8'h00;
         end else if (head.is_header) begin
            out_in.out_byte    = hdr_byte(b, cfg, head.value[31:16], head.value[15:0]);
            out_in.byte_offset = {11'b0, b};
         end else begin
            out_in.out_byte = pay_byte;
         end
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last ? 5'd0 : idx_ff + 5'd1;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/netvar_frame_packer.sv =====
// netvar_frame_packer: top level; configuration registers, front, job queue, back
// depends on nvfp_pkg, nvfp_front, nvfp_jobq, nvfp_back
//
//   channel   direction  handshake           word
//   req_      in         req_push / req_full  req_type (opcode, kind, value)
//   rsp_      out        rsp_pop / rsp_empty  rsp_type (byte, offset, last)
//   csr_      in         csr_write            index + 16-bit data
//
// the front takes one word per cycle while the job queue has room
// the back sends one byte per cycle while the output is free: a word gives 0 to 8 bytes, an end of frame 20 or 21
// sustained rate is set by the single byte output register
// reset is synchronous and clears frame state, sequence number and configuration
// a stalled rsp_pop holds the byte; the queue then fills and raises req_full
module netvar_frame_packer import nvfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    job_push;
   logic    job_full;
   logic    job_empty;
   logic    job_pop;
   job_type job_new;
   job_type job_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_BIG_ENDIAN:    cfg_in.big_endian    = csr_wdata[0];
            REG_PACK_BOOLS:    cfg_in.pack_bools    = csr_wdata[0];
            REG_ALIGN_ENABLE:  cfg_in.align_enable  = csr_wdata[0];
            REG_OBJECT_ID:     cfg_in.object_id     = csr_wdata;
            REG_LIST_CHECKSUM: cfg_in.list_checksum = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nvfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_full (job_full),
      .job_push (job_push),
      .job      (job_new)
   );

   nvfp_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_new),
      .pop      (job_pop),
      .full     (job_full),
      .empty    (job_empty),
      .head     (job_head)
   );

   nvfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .head      (job_head),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // a job is never written into a full queue
   assert property (@(posedge clock) disable iff (reset) !(job_push && job_full))
      else $error("job pushed into full queue");

   // back only retires a job that is present
   assert property (@(posedge clock) disable iff (reset) job_pop |-> !job_empty)
      else $error("job popped from empty queue");

   // output is empty right after reset
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result present after reset");

   // retiring a header job leaves its last header byte, at offset HEADER_BYTES - 1, in the output register
   assert property (@(posedge clock) disable iff (reset)
      (job_pop && job_head.is_header) |=> (!rsp_empty && rsp_data.last
                                           && rsp_data.byte_offset == 16'(HEADER_BYTES - 1)))
      else $error("header job did not end on last header byte");

endmodule
